[design/kspm_pkg.sv]
// Shared types and constants for the keypoint snap pixel mapper.
`default_nettype none

package kspm_pkg;

    localparam int NUM_KEYPOINTS_DEF = 8;
    localparam int VALUE_BITS_DEF    = 12;

    localparam int FIELD_BITS     = 12;
    localparam int INDEX_BITS     = 3;
    localparam int LIMIT_BITS     = 13;
    localparam int COUNT_BITS     = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;
    localparam int S_TDATA_BITS   = 32;
    localparam int M_TDATA_BITS   = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_VALUE_LIMIT = 2'd0,
        CFG_MARGIN      = 2'd1,
        CFG_CIRCULAR    = 2'd2,
        CFG_COUNT       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_MAP  = 1'b1
    } action_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] value_limit;
        logic [FIELD_BITS-1:0] margin;
        logic                  circular_mode;
        logic [COUNT_BITS-1:0] keypoint_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        value_limit:    13'd256,
        margin:         12'd5,
        circular_mode:  1'b0,
        keypoint_count: 4'd0
    };

    typedef struct packed {
        action_t               action;
        logic [INDEX_BITS-1:0] index;
        logic [FIELD_BITS-1:0] value;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

[design/kspm_mod.sv]
// Bit-serial remainder unit for the wrap-around reduction.
`default_nettype none

module kspm_mod #(
    parameter int MW = 15
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [MW-1:0]                   mag,
    input  wire logic [kspm_pkg::LIMIT_BITS-1:0] lim,
    output logic                                 done,
    output logic [kspm_pkg::LIMIT_BITS-1:0]      rem
);
    import kspm_pkg::*;

    localparam int CNTW = $clog2(MW + 1);

    logic [MW-1:0]         mag_reg;
    logic [LIMIT_BITS-1:0] rem_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [LIMIT_BITS:0]   trial;
    logic [LIMIT_BITS:0]   lim_ext;
    logic [LIMIT_BITS-1:0] rem_next;

    assign trial    = {rem_reg, mag_reg[MW-1]};
    assign lim_ext  = {1'b0, lim};
    assign rem_next = (trial >= lim_ext) ? LIMIT_BITS'(trial - lim_ext) : LIMIT_BITS'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

[design/kspm_queue.sv]
// Short queue of decoded words between the front and the back.
`default_nettype none

module kspm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire kspm_pkg::item_t push_item,
    input  wire logic            pop,
    output kspm_pkg::item_t      head_item,
    output logic                 full,
    output logic                 empty
);
    import kspm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    item_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    assign full      = (fill_reg == FW'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/kspm_front.sv]
// Input side: accepts words, decodes them and drops loads to absent slots.
`default_nettype none

module kspm_front #(
    parameter int NUM_KEYPOINTS = kspm_pkg::NUM_KEYPOINTS_DEF,
    parameter int VALUE_BITS    = kspm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [kspm_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output kspm_pkg::item_t                        q_item
);
    import kspm_pkg::*;

    localparam logic [FIELD_BITS-1:0] IN_MASK =
        (VALUE_BITS >= FIELD_BITS) ? {FIELD_BITS{1'b1}} : FIELD_BITS'((1 << VALUE_BITS) - 1);

    logic [INDEX_BITS-1:0] entry_index;
    logic [FIELD_BITS-1:0] entry_value;
    logic [FIELD_BITS-1:0] pixel_value;
    action_t               action;
    logic                  slot_ok;

    assign action      = action_t'(s_tuser);
    assign entry_index = s_tdata[INDEX_BITS-1:0];
    assign entry_value = s_tdata[INDEX_BITS +: FIELD_BITS] & IN_MASK;
    assign pixel_value = s_tdata[INDEX_BITS+FIELD_BITS +: FIELD_BITS] & IN_MASK;
    assign slot_ok     = (32'(entry_index) < NUM_KEYPOINTS);

    assign s_tready = !q_full;

    always_comb
    begin
        q_item.action = action;
        q_item.index  = entry_index;
        q_item.value  = (action == ACT_MAP) ? pixel_value : entry_value;
        q_push        = s_tvalid && !q_full && ((action == ACT_MAP) || slot_ok);
    end

endmodule

`default_nettype wire

[design/kspm_back.sv]
// Back end: keypoint table, nearest-keypoint scan, snapping and result register.
`default_nettype none

module kspm_back #(
    parameter int NUM_KEYPOINTS = kspm_pkg::NUM_KEYPOINTS_DEF,
    parameter int VALUE_BITS    = kspm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kspm_pkg::cfg_t                    cfg,
    input  wire logic                              q_empty,
    input  wire kspm_pkg::item_t                   q_item,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [kspm_pkg::M_TDATA_BITS-1:0]      m_tdata,
    output logic                                   m_tuser
);
    import kspm_pkg::*;

    localparam int AW = (NUM_KEYPOINTS > 1) ? $clog2(NUM_KEYPOINTS) : 1;
    localparam int CW = $clog2(NUM_KEYPOINTS + 1);
    localparam int MW = ((VALUE_BITS > 14) ? VALUE_BITS : 14) + 1;
    localparam int SW = MW + 2;

    back_state_t state_reg;
    back_state_t state_next;

    logic [VALUE_BITS-1:0] kp_mem [NUM_KEYPOINTS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;

    logic [VALUE_BITS-1:0] p_reg;
    logic [VALUE_BITS-1:0] k_reg;
    logic [CW-1:0]         issue_cnt_reg;
    logic [CW-1:0]         n_reg;
    logic [CW-1:0]         n_eff;
    logic                  cmp_vld_reg;
    logic signed [SW-1:0]  best_reg;
    logic signed [SW-1:0]  res_reg;
    logic                  unch_reg;
    logic                  neg_reg;
    logic [FIELD_BITS-1:0] m_mapped_reg;
    logic                  m_unch_reg;
    logic                  m_tvalid_reg;

    logic                  mem_we;
    logic                  rd_issue;
    logic                  mod_start;
    logic                  mod_done;
    logic [LIMIT_BITS-1:0] mod_rem;
    logic                  out_free;
    logic                  out_load;

    logic signed [SW-1:0]  lim_s;
    logic signed [SW-1:0]  m_s;
    logic signed [SW-1:0]  p_s;
    logic signed [SW-1:0]  k_s;
    logic signed [SW-1:0]  mask_s;
    logic signed [SW-1:0]  d_scan;
    logic                  closer;
    logic signed [SW-1:0]  d_k;
    logic signed [SW-1:0]  pk_diff;
    logic signed [SW-1:0]  pk_a2;
    logic signed [SW-1:0]  lin_lo;
    logic signed [SW-1:0]  lin_hi;
    logic signed [SW-1:0]  wrap_x;
    logic                  p_lt_k;
    logic                  down;
    logic signed [SW-1:0]  dec_res;
    logic                  dec_unch;
    logic                  dec_mod;
    logic                  dec_neg;
    logic [MW-1:0]         dec_mag;
    logic signed [SW-1:0]  fix_res;
    logic signed [SW-1:0]  sat_res;

    function automatic logic signed [SW-1:0] dist2(
        input logic [VALUE_BITS-1:0] p,
        input logic [VALUE_BITS-1:0] k,
        input logic signed [SW-1:0]  lim,
        input logic                  circ
    );
        logic signed [SW-1:0] diff;
        logic signed [SW-1:0] a2;
        logic signed [SW-1:0] t;
        diff = $signed(SW'(p)) - $signed(SW'(k));
        a2   = ((diff < 0) ? -diff : diff) <<< 1;
        t    = a2 - lim;
        return circ ? (lim - ((t < 0) ? -t : t)) : a2;
    endfunction

    assign lim_s  = SW'(cfg.value_limit);
    assign m_s    = SW'(cfg.margin);
    assign p_s    = SW'(p_reg);
    assign k_s    = SW'(k_reg);
    assign mask_s = SW'((1 << VALUE_BITS) - 1);
    assign n_eff  = (32'(cfg.keypoint_count) > NUM_KEYPOINTS) ?
                    CW'(NUM_KEYPOINTS) : CW'(cfg.keypoint_count);

    assign rd_addr = issue_cnt_reg[AW-1:0];
    assign wr_addr = AW'(q_item.index);

    assign d_scan = dist2(p_reg, rd_data_reg, lim_s, cfg.circular_mode);
    assign closer = cmp_vld_reg && (d_scan < best_reg);

    always_comb
    begin
        d_k     = dist2(p_reg, k_reg, lim_s, cfg.circular_mode);
        pk_diff = p_s - k_s;
        pk_a2   = ((pk_diff < 0) ? -pk_diff : pk_diff) <<< 1;
        p_lt_k  = (p_s < k_s);
        lin_lo  = k_s - m_s;
        if (lin_lo < 0)
        begin
            lin_lo = '0;
        end
        lin_hi = k_s + m_s;
        if (lin_hi > lim_s - 1)
        begin
            lin_hi = lim_s - 1;
        end
        down    = (pk_a2 < lim_s) ? p_lt_k : !p_lt_k;
        wrap_x  = down ? (k_s - m_s + lim_s) : (k_s + m_s + lim_s);
        dec_neg = (wrap_x < 0);
        dec_mag = MW'(dec_neg ? -wrap_x : wrap_x);
        dec_mod = 1'b0;
        dec_unch = 1'b0;
        priority if (d_k < (m_s <<< 1))
        begin
            dec_res  = p_s;
            dec_unch = 1'b1;
        end
        else if (!cfg.circular_mode)
        begin
            dec_res = p_lt_k ? lin_lo : lin_hi;
        end
        else if (cfg.value_limit == '0)
        begin
            dec_res = '0;
        end
        else
        begin
            dec_res = '0;
            dec_mod = 1'b1;
        end
    end

    assign fix_res = (neg_reg && (mod_rem != '0)) ? (lim_s - SW'(mod_rem)) : SW'(mod_rem);
    assign sat_res = (res_reg < 0) ? '0 : ((res_reg > mask_s) ? mask_s : res_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && (q_item.action == ACT_MAP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((issue_cnt_reg == n_reg) && !cmp_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = dec_mod ? ST_MOD : ST_OUT;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && !q_empty;
        mem_we    = q_pop && (q_item.action == ACT_LOAD);
        rd_issue  = (state_reg == ST_SCAN) && (issue_cnt_reg < n_reg);
        mod_start = (state_reg == ST_DECIDE) && dec_mod;
        out_load  = (state_reg == ST_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= rd_issue;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            kp_mem[wr_addr] <= VALUE_BITS'(q_item.value);
        end
        rd_data_reg <= kp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_reg         <= VALUE_BITS'(q_item.value);
            issue_cnt_reg <= '0;
            n_reg         <= n_eff;
            best_reg      <= lim_s <<< 1;
            k_reg         <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (rd_issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (closer)
            begin
                best_reg <= d_scan;
                k_reg    <= rd_data_reg;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            res_reg  <= dec_res;
            unch_reg <= dec_unch;
            neg_reg  <= dec_neg;
        end
        else if ((state_reg == ST_MOD) && mod_done)
        begin
            res_reg <= fix_res;
        end
        if (out_load)
        begin
            m_mapped_reg <= FIELD_BITS'(sat_res);
            m_unch_reg   <= unch_reg;
        end
    end

    kspm_mod #(
        .MW (MW)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .mag   (dec_mag),
        .lim   (cfg.value_limit),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_mapped_reg);
    assign m_tuser  = m_unch_reg;

`ifndef ASSERT_OFF
    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("remainder finished outside the reduction step");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= n_reg))
        else $error("table scan ran past the keypoint count");

    a_best_falls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> ((state_reg != ST_SCAN) || (best_reg <= $past(best_reg))))
        else $error("best distance grew during the scan");

    a_rem_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (mod_rem < cfg.value_limit))
        else $error("remainder not below the wrap period");
`endif

endmodule

`default_nettype wire

[design/keypoint_snap_pixel_mapper.sv]
// Top level of the keypoint snap pixel mapper: configuration registers and the two halves.
// Usage.
// Words enter on the s_ group: tuser selects a table load (0) or a pixel map (1), and tdata
// carries the slot, the keypoint value and the pixel value. A load writes one keypoint table
// slot and produces nothing; a map produces one word on the m_ group with the snapped value
// in tdata and the unchanged flag in tuser.
// The cfg_ channel writes value_limit, margin, circular_mode and keypoint_count; cfg_ready is
// always high. The user must see that writes are made only while the block is idle; the
// block itself does not enforce it. The front decodes each word into a two-entry queue, so
// input is taken while the back works. A load is written to its table slot when the back
// end takes it. A map holds the back end for the table scan, one read per cycle over the n
// keypoints in use, then a decide and an output step; a snapped circular-mode value with a
// nonzero value_limit also goes through the bit-serial remainder unit, one bit per cycle.
// Reset empties the queue and result register and loads the register defaults; table contents
// are undefined until loaded. While the receiver holds tready low the result stays in its
// register, the back end waits, and input continues until the queue fills.
`default_nettype none

module keypoint_snap_pixel_mapper #(
    parameter int NUM_KEYPOINTS = kspm_pkg::NUM_KEYPOINTS_DEF,
    parameter int VALUE_BITS    = kspm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // entry_index [2:0], entry_value [14:3], pixel_value [26:15], zero fill above
    input  wire logic [kspm_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // action [0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // mapped_value [11:0], zero fill above
    output logic [kspm_pkg::M_TDATA_BITS-1:0]        m_tdata,
    // was_unchanged [0]
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kspm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [kspm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import kspm_pkg::*;

    cfg_t  cfg_reg;
    item_t front_item;
    item_t head_item;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_VALUE_LIMIT: cfg_reg.value_limit    <= cfg_data[LIMIT_BITS-1:0];
                CFG_MARGIN:      cfg_reg.margin         <= cfg_data[FIELD_BITS-1:0];
                CFG_CIRCULAR:    cfg_reg.circular_mode  <= cfg_data[0];
                CFG_COUNT:       cfg_reg.keypoint_count <= cfg_data[COUNT_BITS-1:0];
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    kspm_front #(
        .NUM_KEYPOINTS (NUM_KEYPOINTS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    kspm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    kspm_back #(
        .NUM_KEYPOINTS (NUM_KEYPOINTS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
